[rtl/core/bdd_pkg.sv]
// Shared types, constants and helper functions for the BCD date / DST block.
// No dependencies; used by bdd_dst_eval and bcd_date_dst_and_day_of_year_top.
package bdd_pkg;

   localparam int unsigned YearW   = 8;
   localparam int unsigned MonthW  = 5;
   localparam int unsigned DayW    = 6;
   localparam int unsigned DayNumW = 9;
   localparam int unsigned SumW    = 8;
   localparam int unsigned SunW    = 5;

   localparam logic [MonthW-1:0] MonthFeb = 5'd2;
   localparam logic [MonthW-1:0] MonthMar = 5'd3;
   localparam logic [MonthW-1:0] MonthApr = 5'd4;
   localparam logic [MonthW-1:0] MonthSep = 5'd9;
   localparam logic [MonthW-1:0] MonthOct = 5'd10;

   // two-digit year that is a century but not a multiple of 400 (2100)
   localparam logic [YearW-1:0] YyCentury = 8'd100;

   localparam logic [SunW-1:0] LastDay = 5'd31;

   // weekday offsets of day 31, folded so that (wsum + offset) % 7
   // is the distance from day 31 back to the last Sunday
   localparam logic [SumW-1:0] MarOffset = 8'd5;
   localparam logic [SumW-1:0] OctOffset = 8'd2;

   typedef struct packed {
      logic [YearW-1:0]  yy;
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
      logic              leap;
   } s1_type;

   typedef struct packed {
      logic [SumW-1:0]    wsum;     // yy + yy/4 - yy/100, weekday seed
      logic [DayW-1:0]    day;
      logic               summer;   // April through September
      logic               is_mar;
      logic               is_oct;
      logic [DayNumW-1:0] day_number;
      logic               leap;
   } s2_type;

   typedef struct packed {
      logic               dst;
      logic [DayNumW-1:0] day_number;
      logic               leap;
   } rsp_type;

   // two BCD digits to binary, no digit check (max 165)
   function automatic logic [7:0] bcd_decode(input logic [3:0] hi, input logic [3:0] lo);
      return ({4'b0, hi} << 3) + ({4'b0, hi} << 1) + {4'b0, lo};
   endfunction

   // days before the month in a common year, months past 12 clamp to 365
   function automatic logic [DayNumW-1:0] days_before(input logic [MonthW-1:0] month);
      logic [DayNumW-1:0] d;
      unique case (month)
         5'd0, 5'd1: d = 9'd0;
         5'd2:       d = 9'd31;
         5'd3:       d = 9'd59;
         5'd4:       d = 9'd90;
         5'd5:       d = 9'd120;
         5'd6:       d = 9'd151;
         5'd7:       d = 9'd181;
         5'd8:       d = 9'd212;
         5'd9:       d = 9'd243;
         5'd10:      d = 9'd273;
         5'd11:      d = 9'd304;
         5'd12:      d = 9'd334;
         default:    d = 9'd365;
      endcase
      return d;
   endfunction

   // 8-bit value mod 7 by folding (64 and 8 are both 1 mod 7)
   function automatic logic [2:0] mod7(input logic [SumW-1:0] v);
      logic [6:0] s;
      logic [3:0] t;
      s = {5'b0, v[7:6]} + {1'b0, v[5:0]};
      t = s[6:3] + {1'b0, s[2:0]};
      if (t >= 4'd14) begin
         t = t - 4'd14;
      end else if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

endpackage

[rtl/core/bdd_dst_eval.sv]
// Last-Sunday evaluation for March and October and the final DST decision.
// Depends on bdd_pkg (s2_type, mod7, offsets).
module bdd_dst_eval (
   input  bdd_pkg::s2_type s2,
   output logic            dst
);

   logic [2:0]               mar_back;
   logic [2:0]               oct_back;
   logic [bdd_pkg::SunW-1:0] mar_sun;
   logic [bdd_pkg::SunW-1:0] oct_sun;

   always_comb begin
      mar_back = bdd_pkg::mod7(s2.wsum + bdd_pkg::MarOffset);
      oct_back = bdd_pkg::mod7(s2.wsum + bdd_pkg::OctOffset);
      mar_sun  = bdd_pkg::LastDay - {2'b0, mar_back};
      oct_sun  = bdd_pkg::LastDay - {2'b0, oct_back};
      dst      = s2.summer
               | (s2.is_mar & (s2.day >= {1'b0, mar_sun}))
               | (s2.is_oct & (s2.day <= {1'b0, oct_sun}));
   end

endmodule

[rtl/core/bcd_date_dst_and_day_of_year_top.sv]
// Top level of the BCD date checker: DST flag, day of year, leap flag.
// Depends on bdd_pkg and bdd_dst_eval.

// Each request carries one RTC date (BCD year 20yy, month, day) and yields
// exactly one response. The block is a three-stage pipeline: stage 1 decodes
// the BCD digits and the leap flag, stage 2 forms the weekday seed and the
// day of year from the month table, stage 3 finds the last Sunday of March
// or October and makes the DST decision; stage 3 is also the output
// register. A new request is taken every cycle unless the pipeline is stalled,
// and each stage holds its item when the stage after it is full, so
// back-pressure on the response side stalls without loss and bubbles are
// squeezed out. req_tready is low during reset. Invalid BCD digits decode
// as high nibble times ten plus low nibble; results for such dates follow
// from those values.
module bcd_date_dst_and_day_of_year_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] year_bcd, [12:8] month_bcd, [18:13] day_bcd, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] dst_active, [9:1] day_number, [10] leap_flag, pad
);

   // --- handshake / stage control ---
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;
   logic req_accept;

   assign rdy3       = ~v3_ff | rsp_tready;
   assign rdy2       = ~v2_ff | rdy3;
   assign rdy1       = ~v1_ff | rdy2;
   assign req_tready = rdy1 & ~reset;
   assign req_accept = req_tvalid & req_tready;

   assign v1_in = rdy1 ? req_accept : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // --- stage 1: BCD decode and leap year ---
   bdd_pkg::s1_type s1_ff, s1_in;
   logic [7:0] yy_dec, mon_dec, day_dec;

   always_comb begin
      yy_dec  = bdd_pkg::bcd_decode(req_tdata[7:4], req_tdata[3:0]);
      mon_dec = bdd_pkg::bcd_decode({3'b0, req_tdata[12]}, req_tdata[11:8]);
      day_dec = bdd_pkg::bcd_decode({2'b0, req_tdata[18:17]}, req_tdata[16:13]);
      s1_in.yy    = yy_dec;
      s1_in.month = mon_dec[bdd_pkg::MonthW-1:0];
      s1_in.day   = day_dec[bdd_pkg::DayW-1:0];
      // within 2000..2165 only 2000 is a multiple of 400 and only 2100 a plain century
      s1_in.leap  = (yy_dec[1:0] == 2'b00) && (yy_dec != bdd_pkg::YyCentury);
   end

   // --- stage 2: weekday seed and day of year ---
   bdd_pkg::s2_type s2_ff, s2_in;
   logic [8:0]                  wsum_wide;
   logic [bdd_pkg::DayNumW-1:0] leap_add;

   always_comb begin
      // (2000+yy) + (2000+yy)/4 - (2000+yy)/100 + (2000+yy)/400
      // is 2485 (= 0 mod 7) + yy + yy/4 - [yy >= 100]
      wsum_wide = {1'b0, s1_ff.yy} + {3'b0, s1_ff.yy[7:2]}
                - {8'b0, (s1_ff.yy >= bdd_pkg::YyCentury)};
      leap_add  = {8'b0, (s1_ff.leap && (s1_ff.month > bdd_pkg::MonthFeb))};
      s2_in.wsum       = wsum_wide[bdd_pkg::SumW-1:0];
      s2_in.day        = s1_ff.day;
      s2_in.summer     = (s1_ff.month >= bdd_pkg::MonthApr) &&
                         (s1_ff.month <= bdd_pkg::MonthSep);
      s2_in.is_mar     = (s1_ff.month == bdd_pkg::MonthMar);
      s2_in.is_oct     = (s1_ff.month == bdd_pkg::MonthOct);
      s2_in.day_number = bdd_pkg::days_before(s1_ff.month) + leap_add
                       + {3'b0, s1_ff.day};
      s2_in.leap       = s1_ff.leap;
   end

   // --- stage 3: last Sunday and DST decision ---
   bdd_pkg::rsp_type s3_ff, s3_in;
   logic             dst_eval;

   bdd_dst_eval u_dst_eval (
      .s2  (s2_ff),
      .dst (dst_eval)
   );

   always_comb begin
      s3_in.dst        = dst_eval;
      s3_in.day_number = s2_ff.day_number;
      s3_in.leap       = s2_ff.leap;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {5'b0, s3_ff.leap, s3_ff.day_number, s3_ff.dst};

   // --- assertions ---
   // an accepted request lands in stage 1
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> v1_ff)
      else $error("accepted request did not reach stage 1");

   // a full stage 2 blocked by stage 3 keeps its item
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy2) |=> (v2_ff && $stable(s2_ff)))
      else $error("stage 2 item changed while stalled");

   // common year: day number never exceeds 365 plus the largest decoded day
   a_daynum_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !s3_ff.leap) |-> (s3_ff.day_number <= 9'd410))
      else $error("day number out of range");

endmodule
